// ===== hw/rtl/clstu_pkg.sv =====
package clstu_pkg;

	// Memory address width; every address is masked to these low bits.
	localparam int ADDR_BITS = 16;
	localparam int MEM_DEPTH = 1 << ADDR_BITS;

	localparam logic [15:0] STACK_BASE = 16'h0100;

	localparam logic [3:0] ACT_HWR  = 4'd0;
	localparam logic [3:0] ACT_HRD  = 4'd1;
	localparam logic [3:0] ACT_LDAI = 4'd2;
	localparam logic [3:0] ACT_LDAA = 4'd3;
	localparam logic [3:0] ACT_STA  = 4'd4;
	localparam logic [3:0] ACT_TAX  = 4'd5;
	localparam logic [3:0] ACT_TAY  = 4'd6;
	localparam logic [3:0] ACT_TXA  = 4'd7;
	localparam logic [3:0] ACT_TYA  = 4'd8;
	localparam logic [3:0] ACT_PHA  = 4'd9;
	localparam logic [3:0] ACT_PLA  = 4'd10;
	localparam logic [3:0] ACT_NOP  = 4'd11;

	typedef enum logic [3:0] {
		OP_HWR,
		OP_HRD,
		OP_LDAI,
		OP_LDAA,
		OP_STA,
		OP_TAX,
		OP_TAY,
		OP_TXA,
		OP_TYA,
		OP_PHA,
		OP_PLA,
		OP_NOP,
		OP_NONE
	} op_t;

	typedef struct packed {
		logic [3:0]  action;
		logic [15:0] host_address;
		logic [7:0]  host_data;
	} req_t;

	typedef struct packed {
		logic [7:0]  accumulator;
		logic [7:0]  index_x;
		logic [7:0]  index_y;
		logic [7:0]  stack_pointer;
		logic [15:0] program_counter;
		logic        zero_flag;
		logic        negative_flag;
		logic [7:0]  read_data;
		logic [31:0] cycle_total;
	} rsp_t;

	typedef struct packed {
		op_t         op;
		logic [15:0] addr;
		logic [7:0]  data;
	} cmd_t;

	// Emulated machine cycles charged for each operation.
	function automatic logic [2:0] op_cost(op_t op);
		logic [2:0] cost;
		unique case (op)
			OP_LDAI, OP_TAX, OP_TAY, OP_TXA, OP_TYA, OP_NOP: cost = 3'd2;
			OP_PHA:                                           cost = 3'd3;
			OP_LDAA, OP_STA, OP_PLA:                          cost = 3'd4;
			default:                                          cost = 3'd0;
		endcase
		return cost;
	endfunction

endpackage

// ===== hw/rtl/clstu_req_if.sv =====
interface clstu_req_if;
	logic               valid;
	logic               ready;
	clstu_pkg::req_t    data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// ===== hw/rtl/clstu_rsp_if.sv =====
interface clstu_rsp_if;
	logic               valid;
	logic               ready;
	clstu_pkg::rsp_t    data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// ===== hw/rtl/clstu_cfg_if.sv =====
interface clstu_cfg_if;
	logic        valid;
	logic        ready;
	logic [15:0] data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// ===== hw/rtl/clstu_front.sv =====
module clstu_front (
	clstu_req_if.sink         req,
	input  logic              full,
	output logic              push,
	output clstu_pkg::cmd_t   push_cmd
);

	assign req.ready = !full;
	assign push      = req.valid && !full;

	always_comb begin
		push_cmd.addr = req.data.host_address;
		push_cmd.data = req.data.host_data;
		unique case (req.data.action)
			clstu_pkg::ACT_HWR:  push_cmd.op = clstu_pkg::OP_HWR;
			clstu_pkg::ACT_HRD:  push_cmd.op = clstu_pkg::OP_HRD;
			clstu_pkg::ACT_LDAI: push_cmd.op = clstu_pkg::OP_LDAI;
			clstu_pkg::ACT_LDAA: push_cmd.op = clstu_pkg::OP_LDAA;
			clstu_pkg::ACT_STA:  push_cmd.op = clstu_pkg::OP_STA;
			clstu_pkg::ACT_TAX:  push_cmd.op = clstu_pkg::OP_TAX;
			clstu_pkg::ACT_TAY:  push_cmd.op = clstu_pkg::OP_TAY;
			clstu_pkg::ACT_TXA:  push_cmd.op = clstu_pkg::OP_TXA;
			clstu_pkg::ACT_TYA:  push_cmd.op = clstu_pkg::OP_TYA;
			clstu_pkg::ACT_PHA:  push_cmd.op = clstu_pkg::OP_PHA;
			clstu_pkg::ACT_PLA:  push_cmd.op = clstu_pkg::OP_PLA;
			clstu_pkg::ACT_NOP:  push_cmd.op = clstu_pkg::OP_NOP;
			default:             push_cmd.op = clstu_pkg::OP_NONE;
		endcase
	end

endmodule

// ===== hw/rtl/clstu_queue.sv =====
module clstu_queue (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  clstu_pkg::cmd_t   push_cmd,
	output logic              full,
	input  logic              pop,
	output logic              valid,
	output clstu_pkg::cmd_t   head
);

	clstu_pkg::cmd_t entry_q [2];
	logic            wr_ptr_q;
	logic            rd_ptr_q;
	logic [1:0]      count_q;

	assign full  = (count_q == 2'd2);
	assign valid = (count_q != 2'd0);
	assign head  = entry_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			if (push && !pop) begin
				count_q <= count_q + 2'd1;
			end else if (pop && !push) begin
				count_q <= count_q - 2'd1;
			end
		end
	end

endmodule

// ===== hw/rtl/clstu_back.sv =====
module clstu_back (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              q_valid,
	input  clstu_pkg::cmd_t   q_cmd,
	output logic              pop,
	clstu_cfg_if.sink         cfg,
	clstu_rsp_if.source       rsp
);

	typedef enum logic [1:0] {
		S_IDLE,
		S_ABS1,
		S_ABS2,
		S_RD
	} state_t;

	state_t          state_q, state_d;
	clstu_pkg::cmd_t cmd_q;
	logic [7:0]      acc_q, x_q, y_q, sp_q;
	logic [15:0]     pc_q;
	logic            z_q, n_q;
	logic [31:0]     cycle_q;
	logic [7:0]      lo_q;
	logic [7:0]      rd_q;
	logic            rsp_valid_q;
	clstu_pkg::rsp_t rsp_data_q;

	logic [7:0] mem_q [clstu_pkg::MEM_DEPTH];

	logic [7:0]      acc_d, x_d, y_d, sp_d;
	logic [15:0]     pc_d;
	logic            z_d, n_d;
	logic [31:0]     cycle_d;
	logic [7:0]      rdata_d;
	logic            flag_ld;
	logic [7:0]      flag_val;
	logic            done;
	logic            out_free;
	logic            mem_we, mem_re;
	logic [15:0]     mem_addr;
	logic [7:0]      mem_wdata;
	logic [7:0]      sp_inc;
	clstu_pkg::op_t  done_op;

	assign cfg.ready = 1'b1;
	assign out_free  = !rsp_valid_q || rsp.ready;
	assign sp_inc    = sp_q + 8'd1;
	assign done_op   = (state_q == S_IDLE) ? q_cmd.op : cmd_q.op;

	always_comb begin
		state_d   = state_q;
		mem_we    = 1'b0;
		mem_re    = 1'b0;
		mem_addr  = 16'h0000;
		mem_wdata = acc_q;
		pop       = 1'b0;
		done      = 1'b0;
		acc_d     = acc_q;
		x_d       = x_q;
		y_d       = y_q;
		sp_d      = sp_q;
		pc_d      = pc_q;
		rdata_d   = 8'h00;
		flag_ld   = 1'b0;
		flag_val  = 8'h00;
		unique case (state_q)
			S_IDLE: begin
				if (q_valid) begin
					unique case (q_cmd.op)
						clstu_pkg::OP_HRD: begin
							mem_re   = 1'b1;
							mem_addr = q_cmd.addr;
							pop      = 1'b1;
							state_d  = S_RD;
						end
						clstu_pkg::OP_LDAI: begin
							mem_re   = 1'b1;
							mem_addr = pc_q;
							pc_d     = pc_q + 16'd1;
							pop      = 1'b1;
							state_d  = S_RD;
						end
						clstu_pkg::OP_LDAA, clstu_pkg::OP_STA: begin
							mem_re   = 1'b1;
							mem_addr = pc_q;
							pc_d     = pc_q + 16'd1;
							pop      = 1'b1;
							state_d  = S_ABS1;
						end
						clstu_pkg::OP_PLA: begin
							mem_re   = 1'b1;
							mem_addr = clstu_pkg::STACK_BASE + {8'h00, sp_inc};
							sp_d     = sp_inc;
							pop      = 1'b1;
							state_d  = S_RD;
						end
						default: begin
							// Operations that need no memory read finish here and need the
							// output register free.
							if (out_free) begin
								pop  = 1'b1;
								done = 1'b1;
								unique case (q_cmd.op)
									clstu_pkg::OP_HWR: begin
										mem_we    = 1'b1;
										mem_addr  = q_cmd.addr;
										mem_wdata = q_cmd.data;
									end
									clstu_pkg::OP_PHA: begin
										mem_we   = 1'b1;
										mem_addr = clstu_pkg::STACK_BASE + {8'h00, sp_q};
										sp_d     = sp_q - 8'd1;
									end
									clstu_pkg::OP_TAX: begin
										x_d      = acc_q;
										flag_ld  = 1'b1;
										flag_val = acc_q;
									end
									clstu_pkg::OP_TAY: begin
										y_d      = acc_q;
										flag_ld  = 1'b1;
										flag_val = acc_q;
									end
									clstu_pkg::OP_TXA: begin
										acc_d    = x_q;
										flag_ld  = 1'b1;
										flag_val = x_q;
									end
									clstu_pkg::OP_TYA: begin
										acc_d    = y_q;
										flag_ld  = 1'b1;
										flag_val = y_q;
									end
									default: begin
									end
								endcase
							end
						end
					endcase
				end
			end
			S_ABS1: begin
				mem_re   = 1'b1;
				mem_addr = pc_q;
				pc_d     = pc_q + 16'd1;
				state_d  = S_ABS2;
			end
			S_ABS2: begin
				// The high operand byte is in the read register, the low one in lo_q.
				if (cmd_q.op == clstu_pkg::OP_STA) begin
					if (out_free) begin
						mem_we   = 1'b1;
						mem_addr = {rd_q, lo_q};
						done     = 1'b1;
						state_d  = S_IDLE;
					end
				end else begin
					mem_re   = 1'b1;
					mem_addr = {rd_q, lo_q};
					state_d  = S_RD;
				end
			end
			S_RD: begin
				if (out_free) begin
					done    = 1'b1;
					state_d = S_IDLE;
					if (cmd_q.op == clstu_pkg::OP_HRD) begin
						rdata_d = rd_q;
					end else begin
						acc_d    = rd_q;
						flag_ld  = 1'b1;
						flag_val = rd_q;
					end
				end
			end
			default: begin
			end
		endcase

		z_d = flag_ld ? (flag_val == 8'h00) : z_q;
		n_d = flag_ld ? flag_val[7] : n_q;
		cycle_d = done ? (cycle_q + {29'd0, clstu_pkg::op_cost(done_op)}) : cycle_q;

		// A start address write loads the program counter at once.
		if (cfg.valid) begin
			pc_d = cfg.data;
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem_q[mem_addr[clstu_pkg::ADDR_BITS-1:0]] <= mem_wdata;
		end else if (mem_re) begin
			rd_q <= mem_q[mem_addr[clstu_pkg::ADDR_BITS-1:0]];
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			cmd_q <= q_cmd;
		end
		if (state_q == S_ABS1) begin
			lo_q <= rd_q;
		end
		if (done) begin
			rsp_data_q.accumulator     <= acc_d;
			rsp_data_q.index_x         <= x_d;
			rsp_data_q.index_y         <= y_d;
			rsp_data_q.stack_pointer   <= sp_d;
			rsp_data_q.program_counter <= pc_d;
			rsp_data_q.zero_flag       <= z_d;
			rsp_data_q.negative_flag   <= n_d;
			rsp_data_q.read_data       <= rdata_d;
			rsp_data_q.cycle_total     <= cycle_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			acc_q       <= 8'h00;
			x_q         <= 8'h00;
			y_q         <= 8'h00;
			sp_q        <= 8'hFF;
			pc_q        <= 16'h0000;
			z_q         <= 1'b0;
			n_q         <= 1'b0;
			cycle_q     <= 32'd0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			acc_q   <= acc_d;
			x_q     <= x_d;
			y_q     <= y_d;
			sp_q    <= sp_d;
			pc_q    <= pc_d;
			z_q     <= z_d;
			n_q     <= n_d;
			cycle_q <= cycle_d;
			if (done) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	assign rsp.valid = rsp_valid_q;
	assign rsp.data  = rsp_data_q;

endmodule

// ===== hw/rtl/cpu_load_store_transfer_unit_core.sv =====
// An accepted transfer enters a two-entry queue at that edge. The executor loads the result
// register in its last state: idle for host writes, transfers, NOP and PHA; the read state
// for host reads, LDA immediate and PLA; the second operand state for STA absolute; both
// operand states and then the read state for LDA absolute. It takes the next transfer only
// when done with the last, as the single-port byte memory sets; a stalled result holds it.
// Reset clears A, X, Y, the flags and the cycle count, sets SP to 0xFF and PC to 0.
module cpu_load_store_transfer_unit_core (
	input  logic          clk,
	input  logic          arst_n,
	clstu_req_if.sink     req,
	clstu_cfg_if.sink     cfg,
	clstu_rsp_if.source   rsp
);

	logic            q_full;
	logic            q_push;
	clstu_pkg::cmd_t q_push_cmd;
	logic            q_pop;
	logic            q_valid;
	clstu_pkg::cmd_t q_head;

	clstu_front u_front (
		.req      (req),
		.full     (q_full),
		.push     (q_push),
		.push_cmd (q_push_cmd)
	);

	clstu_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (q_push),
		.push_cmd (q_push_cmd),
		.full     (q_full),
		.pop      (q_pop),
		.valid    (q_valid),
		.head     (q_head)
	);

	clstu_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.q_valid (q_valid),
		.q_cmd   (q_head),
		.pop     (q_pop),
		.cfg     (cfg),
		.rsp     (rsp)
	);

endmodule

// ===== sim/exec_checker.sv =====
module exec_checker (
	input  logic        clk,
	input  logic        arst_n,
	clstu_req_if        req,
	clstu_cfg_if        cfg,
	clstu_rsp_if        rsp,
	output int unsigned errors,
	output int unsigned pending
);
	import clstu_pkg::*;

	localparam logic [15:0] ADDR_MASK = 16'(MEM_DEPTH - 1);

	logic [7:0]  ram [0:MEM_DEPTH-1];
	logic [7:0]  acc_q;
	logic [7:0]  x_q;
	logic [7:0]  y_q;
	logic [7:0]  sp_q;
	logic [15:0] pc_q;
	logic        z_q;
	logic        n_q;
	logic [31:0] cycles_q;
	rsp_t        expected_results [$];
	rsp_t        want;

	function automatic logic [7:0] fetch_operand();
		logic [7:0] b;
		b = ram[pc_q & ADDR_MASK];
		pc_q = pc_q + 16'd1;
		return b;
	endfunction

	function automatic void load_flags(logic [7:0] v);
		z_q = (v == 8'h00);
		n_q = v[7];
	endfunction

	// Applies one action to the shadow machine and returns the result it must report.
	function automatic rsp_t execute_action(req_t it);
		rsp_t       r;
		logic [7:0] lo;
		logic [7:0] hi;
		logic [7:0] rd;
		logic [2:0] cost;
		rd = 8'h00;
		cost = 3'd0;
		case (it.action)
			ACT_HWR: ram[it.host_address & ADDR_MASK] = it.host_data;
			ACT_HRD: rd = ram[it.host_address & ADDR_MASK];
			ACT_LDAI: begin
				acc_q = fetch_operand();
				load_flags(acc_q);
				cost = 3'd2;
			end
			ACT_LDAA: begin
				lo = fetch_operand();
				hi = fetch_operand();
				acc_q = ram[{hi, lo} & ADDR_MASK];
				load_flags(acc_q);
				cost = 3'd4;
			end
			ACT_STA: begin
				lo = fetch_operand();
				hi = fetch_operand();
				ram[{hi, lo} & ADDR_MASK] = acc_q;
				cost = 3'd4;
			end
			ACT_TAX: begin
				x_q = acc_q;
				load_flags(x_q);
				cost = 3'd2;
			end
			ACT_TAY: begin
				y_q = acc_q;
				load_flags(y_q);
				cost = 3'd2;
			end
			ACT_TXA: begin
				acc_q = x_q;
				load_flags(acc_q);
				cost = 3'd2;
			end
			ACT_TYA: begin
				acc_q = y_q;
				load_flags(acc_q);
				cost = 3'd2;
			end
			ACT_PHA: begin
				ram[(STACK_BASE + {8'h00, sp_q}) & ADDR_MASK] = acc_q;
				sp_q = sp_q - 8'd1;
				cost = 3'd3;
			end
			ACT_PLA: begin
				sp_q = sp_q + 8'd1;
				acc_q = ram[(STACK_BASE + {8'h00, sp_q}) & ADDR_MASK];
				load_flags(acc_q);
				cost = 3'd4;
			end
			ACT_NOP: cost = 3'd2;
			default: ;
		endcase
		cycles_q = cycles_q + {29'd0, cost};
		r.accumulator     = acc_q;
		r.index_x         = x_q;
		r.index_y         = y_q;
		r.stack_pointer   = sp_q;
		r.program_counter = pc_q;
		r.zero_flag       = z_q;
		r.negative_flag   = n_q;
		r.read_data       = rd;
		r.cycle_total     = cycles_q;
		return r;
	endfunction

	task automatic check_field(string what, logic [31:0] want_v, logic [31:0] got_v);
		if (got_v !== want_v) begin
			errors++;
			$display("%0t: %s expected %h, got %h", $time, what, want_v, got_v);
		end
	endtask

	// The response is compared before a new request is predicted, so that a result
	// can never be matched against the prediction of the same edge.
	always @(posedge clk) begin
		if (!arst_n) begin
			acc_q = 8'h00;
			x_q = 8'h00;
			y_q = 8'h00;
			sp_q = 8'hFF;
			pc_q = 16'h0000;
			z_q = 1'b0;
			n_q = 1'b0;
			cycles_q = 32'd0;
			expected_results.delete();
			errors = 0;
		end else begin
			if (rsp.valid && rsp.ready) begin
				if (expected_results.size() == 0) begin
					errors++;
					$display("%0t: result %h with nothing expected", $time, rsp.data);
				end else begin
					want = expected_results.pop_front();
					check_field("accumulator", 32'(want.accumulator),
						32'(rsp.data.accumulator));
					check_field("index_x", 32'(want.index_x), 32'(rsp.data.index_x));
					check_field("index_y", 32'(want.index_y), 32'(rsp.data.index_y));
					check_field("stack_pointer", 32'(want.stack_pointer),
						32'(rsp.data.stack_pointer));
					check_field("program_counter", 32'(want.program_counter),
						32'(rsp.data.program_counter));
					check_field("zero_flag", 32'(want.zero_flag),
						32'(rsp.data.zero_flag));
					check_field("negative_flag", 32'(want.negative_flag),
						32'(rsp.data.negative_flag));
					check_field("read_data", 32'(want.read_data),
						32'(rsp.data.read_data));
					check_field("cycle_total", want.cycle_total, rsp.data.cycle_total);
				end
			end
			if (cfg.valid && cfg.ready) begin
				pc_q = cfg.data;
			end
			if (req.valid && req.ready)
				expected_results.push_back(execute_action(req.data));
		end
		pending = expected_results.size();
	end

endmodule

// ===== sim/testbench.sv =====
module testbench;
	import clstu_pkg::*;

	localparam logic [15:0] ADDR_MASK = 16'(MEM_DEPTH - 1);
	localparam logic [3:0]  ACT_LAST = 4'hF;
	localparam int unsigned QUIET_LIMIT = 3000;
	localparam int unsigned PHASE_ITEMS = 305;

	logic clk;
	logic arst_n;

	clstu_req_if req_ch ();
	clstu_cfg_if cfg_ch ();
	clstu_rsp_if rsp_ch ();

	int unsigned errors;
	int unsigned exp_count;

	cpu_load_store_transfer_unit_core u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.cfg    (cfg_ch),
		.rsp    (rsp_ch)
	);

	exec_checker u_checker (
		.clk     (clk),
		.arst_n  (arst_n),
		.req     (req_ch),
		.cfg     (cfg_ch),
		.rsp     (rsp_ch),
		.errors  (errors),
		.pending (exp_count)
	);

	// Stimulus-side view of the machine: only what is needed to keep every read on
	// memory that has been written, and to know where absolute operands point.
	logic [7:0]  img [0:MEM_DEPTH-1];
	bit          written [0:MEM_DEPTH-1];
	bit          known [0:MEM_DEPTH-1];
	logic [15:0] filled [$];
	logic [15:0] pc_t;
	logic [7:0]  sp_t;

	int unsigned snd_idle;
	int unsigned rcv_idle;
	int unsigned stall_len;
	int unsigned sent;

	logic [3:0]  moves [4] = '{ACT_TAX, ACT_TAY, ACT_TXA, ACT_TYA};
	logic [15:0] start_tab [6] = '{16'hFFFF, 16'h0000, 16'h0000, 16'h0000, 16'h8000, 16'h0000};

	wire moved = (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) ||
		(cfg_ch.valid && cfg_ch.ready);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	function automatic logic [15:0] wrap(logic [15:0] a);
		return a & ADDR_MASK;
	endfunction

	function automatic logic [7:0] rand_byte();
		case ($urandom_range(9))
			0: return 8'h00;
			1: return 8'hFF;
			default: return 8'($urandom);
		endcase
	endfunction

	function automatic void note_write(logic [15:0] a, logic [7:0] v, bit is_known);
		logic [15:0] m;
		m = wrap(a);
		if (!written[m])
			filled.push_back(m);
		written[m] = 1'b1;
		known[m] = is_known;
		img[m] = v;
	endfunction

	function automatic void track_item(req_t it);
		logic [15:0] ea;
		case (it.action)
			ACT_HWR: note_write(it.host_address, it.host_data, 1'b1);
			ACT_LDAI: pc_t = pc_t + 16'd1;
			ACT_LDAA: pc_t = pc_t + 16'd2;
			ACT_STA: begin
				ea = {img[wrap(pc_t + 16'd1)], img[wrap(pc_t)]};
				note_write(ea, 8'h00, 1'b0);
				pc_t = pc_t + 16'd2;
			end
			ACT_PHA: begin
				note_write(STACK_BASE + {8'h00, sp_t}, 8'h00, 1'b0);
				sp_t = sp_t - 8'd1;
			end
			ACT_PLA: sp_t = sp_t + 8'd1;
			default: ;
		endcase
	endfunction

	// Entered and left at a falling edge; valid stays high into the next item.
	task automatic send_item(logic [3:0] act, logic [15:0] addr, logic [7:0] data);
		req_t it;
		it.action = act;
		it.host_address = addr;
		it.host_data = data;
		while ($urandom_range(99) < snd_idle) begin
			req_ch.valid <= 1'b0;
			@(negedge clk);
		end
		req_ch.valid <= 1'b1;
		req_ch.data <= it;
		@(posedge clk);
		while (!req_ch.ready)
			@(posedge clk);
		track_item(it);
		sent++;
		@(negedge clk);
	endtask

	task automatic prime(logic [15:0] a);
		if (!written[wrap(a)])
			send_item(ACT_HWR, a, rand_byte());
	endtask

	task automatic drain();
		req_ch.valid <= 1'b0;
		while (exp_count != 0)
			@(negedge clk);
		repeat (12) @(negedge clk);
	endtask

	task automatic load_start(logic [15:0] v);
		cfg_ch.valid <= 1'b1;
		cfg_ch.data <= v;
		@(posedge clk);
		while (!cfg_ch.ready)
			@(posedge clk);
		pc_t = v;
		@(negedge clk);
		cfg_ch.valid <= 1'b0;
	endtask

	// Most actions come as well-formed sequences: operand bytes and load sources are
	// host-written first wherever the memory there was never written.
	task automatic random_action();
		int unsigned r;
		logic [15:0] ea;
		r = $urandom_range(99);
		if (r < 10) begin
			send_item(ACT_HWR, 16'($urandom), rand_byte());
		end else if (r < 18) begin
			send_item(ACT_HRD, filled[$urandom_range(filled.size() - 1)], rand_byte());
		end else if (r < 30) begin
			prime(pc_t);
			send_item(ACT_LDAI, 16'($urandom), rand_byte());
		end else if (r < 52) begin
			if (!known[wrap(pc_t)] || !known[wrap(pc_t + 16'd1)]) begin
				case ($urandom_range(3))
					0, 1: ea = filled[$urandom_range(filled.size() - 1)];
					2: ea = 16'($urandom);
					default: ea = $urandom_range(1) ? 16'hFFFF : 16'h0000;
				endcase
				send_item(ACT_HWR, pc_t, ea[7:0]);
				send_item(ACT_HWR, pc_t + 16'd1, ea[15:8]);
			end
			ea = {img[wrap(pc_t + 16'd1)], img[wrap(pc_t)]};
			if (r < 40) begin
				prime(ea);
				send_item(ACT_LDAA, 16'($urandom), rand_byte());
			end else begin
				send_item(ACT_STA, 16'($urandom), rand_byte());
			end
		end else if (r < 72) begin
			send_item(moves[$urandom_range(3)], 16'($urandom), rand_byte());
		end else if (r < 81) begin
			send_item(ACT_PHA, 16'($urandom), rand_byte());
		end else if (r < 90) begin
			prime(STACK_BASE + {8'h00, 8'(sp_t + 8'd1)});
			send_item(ACT_PLA, 16'($urandom), rand_byte());
		end else if (r < 96) begin
			send_item(ACT_NOP, 16'($urandom), rand_byte());
		end else begin
			send_item(4'($urandom_range(ACT_LAST, ACT_NOP + 4'd1)), 16'($urandom), rand_byte());
		end
	endtask

	// Receiver: random back-pressure, plus long hold-offs requested by the stimulus.
	initial begin
		rsp_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (stall_len != 0) begin
				rsp_ch.ready <= 1'b0;
				repeat (stall_len - 1) @(negedge clk);
				stall_len = 0;
			end else begin
				rsp_ch.ready <= ($urandom_range(99) >= rcv_idle);
			end
		end
	end

	initial begin
		int unsigned quiet;
		quiet = 0;
		while (quiet < QUIET_LIMIT) begin
			@(posedge clk);
			if (moved)
				quiet = 0;
			else
				quiet++;
		end
		$display("Mismatches found");
		$finish;
	end

	initial begin
		int unsigned goal;
		req_ch.valid = 1'b0;
		req_ch.data = '0;
		cfg_ch.valid = 1'b0;
		cfg_ch.data = 16'h0000;
		snd_idle = 20;
		rcv_idle = 86;
		stall_len = 0;
		sent = 0;
		sp_t = 8'hFF;
		pc_t = 16'h0000;
		start_tab[2] = 16'($urandom);
		start_tab[3] = 16'($urandom);
		start_tab[5] = 16'($urandom);
		arst_n = 1'b0;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Directed: program counter wrap, stack pointer wrap both ways, flags, extremes.
		load_start(16'hFFFE);
		send_item(ACT_HWR, 16'hFFFE, 8'h00);
		send_item(ACT_HWR, 16'hFFFF, 8'h80);
		send_item(ACT_HWR, 16'h0000, 8'hFF);
		send_item(ACT_HWR, 16'h0001, 8'hFF);
		send_item(ACT_HWR, 16'h0002, 8'h00);
		send_item(ACT_HWR, 16'h0003, 8'h00);
		send_item(ACT_HWR, 16'h0100, 8'h7F);
		send_item(ACT_LDAI, 16'hFFFF, 8'hFF);
		send_item(ACT_LDAI, 16'h0000, 8'h00);
		send_item(ACT_LDAA, 16'($urandom), rand_byte());
		send_item(ACT_TAX, 16'($urandom), rand_byte());
		send_item(ACT_STA, 16'($urandom), rand_byte());
		send_item(ACT_HRD, 16'h0000, rand_byte());
		send_item(ACT_HRD, 16'hFFFF, rand_byte());
		send_item(ACT_TAY, 16'($urandom), rand_byte());
		send_item(ACT_PLA, 16'($urandom), rand_byte());
		send_item(ACT_TXA, 16'($urandom), rand_byte());
		send_item(ACT_PHA, 16'($urandom), rand_byte());
		send_item(ACT_TYA, 16'($urandom), rand_byte());
		send_item(ACT_PHA, 16'($urandom), rand_byte());
		send_item(ACT_PLA, 16'($urandom), rand_byte());
		send_item(ACT_NOP, 16'($urandom), rand_byte());
		send_item(ACT_NOP + 4'd1, 16'($urandom), rand_byte());
		send_item(ACT_LAST, 16'($urandom), rand_byte());
		send_item(ACT_HRD, 16'h0100, rand_byte());

		for (int p = 0; p < 6; p++) begin
			if (p == 2) begin
				snd_idle = 86;
				rcv_idle = 20;
			end else if (p == 4) begin
				snd_idle = 0;
				rcv_idle = 0;
			end
			drain();
			load_start(start_tab[p]);
			if (p == 0 || p == 4)
				stall_len = 300;
			goal = sent + PHASE_ITEMS;
			while (sent < goal)
				random_action();
		end
		drain();

		if (errors == 0 && exp_count == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule
